### rtl/lnser_pkg.sv
// Shared types and constants for the natural log series unit.
package lnser_pkg;

    // Operand and result widths
    localparam int OPND_W  = 32;
    localparam int LOG_W   = 32;

    // Range reduction: mantissa has 32 fraction bits, at most 2.0
    localparam int MANT_W  = 34;
    localparam int MAG_W   = 33;
    localparam int DEN_W   = 35;

    // Quotient |z| in Q.30, computed one bit per stage
    localparam int QUO_W   = 30;
    localparam int NUM_HI_W = 33;

    // Series accumulator and signed total
    localparam int SUM_W   = 34;
    localparam int TOT_W   = 40;

    localparam logic signed [TOT_W-1:0] LN2_Q30 = 40'sd744261118;
    localparam logic [LOG_W-1:0] LOG_MIN = 32'h8000_0000;

    // Side information that travels with each request
    typedef struct packed {
        logic              vld;
        logic              err;
        logic              neg;
        logic signed [4:0] k;
    } lnser_tag_t;

endpackage

### rtl/lnser_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
module lnser_div
    import lnser_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 ce,
    input  lnser_tag_t           tag_in,
    input  logic [NUM_HI_W-1:0]  num_hi,
    input  logic [QUO_W-1:0]     num_lo,
    input  logic [DEN_W-1:0]     den,
    output lnser_tag_t           tag_out,
    output logic [QUO_W-1:0]     quo
);

    wire lnser_tag_t         tag_w [0:QUO_W];
    wire [DEN_W-1:0]         rem_w [0:QUO_W];
    wire [QUO_W-1:0]         lo_w  [0:QUO_W];
    wire [DEN_W-1:0]         den_w [0:QUO_W];
    wire [QUO_W-1:0]         quo_w [0:QUO_W];

    assign tag_w[0] = tag_in;
    assign rem_w[0] = DEN_W'(num_hi);
    assign lo_w[0]  = num_lo;
    assign den_w[0] = den;
    assign quo_w[0] = '0;

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        lnser_tag_t       tag_reg;
        logic [DEN_W-1:0] rem_reg;
        logic [QUO_W-1:0] lo_reg;
        logic [DEN_W-1:0] den_reg;
        logic [QUO_W-1:0] quo_reg;
        logic [DEN_W:0]   trial;
        logic             fits;

        // shift in next dividend bit and try a subtract
        assign trial = {rem_w[j], lo_w[j][QUO_W-1-j]};
        assign fits  = trial >= {1'b0, den_w[j]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg.vld <= 1'b0;
            end else if (ce) begin
                tag_reg <= tag_w[j];
            end
            if (ce) begin
                rem_reg <= fits ? DEN_W'(trial - {1'b0, den_w[j]}) : DEN_W'(trial);
                lo_reg  <= lo_w[j];
                den_reg <= den_w[j];
                quo_reg <= {quo_w[j][QUO_W-2:0], fits};
            end
        end

        assign tag_w[j+1] = tag_reg;
        assign rem_w[j+1] = rem_reg;
        assign lo_w[j+1]  = lo_reg;
        assign den_w[j+1] = den_reg;
        assign quo_w[j+1] = quo_reg;
    end

    assign tag_out = tag_w[QUO_W];
    assign quo     = quo_w[QUO_W];

endmodule

### rtl/natural_log_series_unit.sv
// Natural log of a Q16.16 operand by range reduction and an atanh series.
// Pipeline length is set by the 30-stage quotient divider and two stages
// per series term.
// Throughput: one request per cycle; the whole pipeline holds while the
// output register is full and not taken.
// Reset: synchronous active-low aresetn clears all valid bits.
module natural_log_series_unit
    import lnser_pkg::*;
#(
    parameter int SERIES_TERMS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] log_value
    output logic        m_tuser    // [0] domain_error
);

    logic ce;

    // pipeline advances when the output register can move
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // Stage 0: input register
    logic              s0_vld_reg;
    logic [OPND_W-1:0] s0_x_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
        end else if (ce) begin
            s0_vld_reg <= s_tvalid;
        end
        if (ce) begin
            s0_x_reg <= s_tdata;
        end
    end

    // Stage 1: leading one position and power-of-two shift count
    logic [4:0]        msb;
    logic              pow2;
    logic signed [5:0] k_full;
    lnser_tag_t        s1_tag_reg;
    logic [OPND_W-1:0] s1_x_reg;

    always_comb begin
        msb = '0;
        for (int i = 0; i < OPND_W; i++) begin
            if (s0_x_reg[i]) begin
                msb = 5'(i);
            end
        end
        pow2 = (s0_x_reg & (s0_x_reg - 32'd1)) == '0;
        if (msb >= 5'd17) begin
            k_full = 6'(signed'({1'b0, msb})) - 6'sd16 - 6'(pow2);
        end else if (msb >= 5'd15) begin
            k_full = '0;
        end else begin
            k_full = 6'(signed'({1'b0, msb})) - 6'sd15;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_tag_reg.vld <= 1'b0;
        end else if (ce) begin
            s1_tag_reg.vld <= s0_vld_reg;
        end
        if (ce) begin
            s1_tag_reg.err <= s0_x_reg == '0;
            s1_tag_reg.neg <= 1'b0;
            s1_tag_reg.k   <= 5'(k_full);
            s1_x_reg       <= s0_x_reg;
        end
    end

    // Stage 2: mantissa in [0.5, 2], |m-1|, m+1 and rounded dividend
    logic [47:0]          m48;
    logic [MANT_W-1:0]    mant;
    logic [4:0]           kneg;
    logic                 mneg;
    logic [MAG_W-1:0]     mag;
    logic [DEN_W-1:0]     den_next;
    logic [62:0]          num;
    lnser_tag_t           s2_tag_reg;
    logic [NUM_HI_W-1:0]  s2_hi_reg;
    logic [QUO_W-1:0]     s2_lo_reg;
    logic [DEN_W-1:0]     s2_den_reg;

    always_comb begin
        m48  = {s1_x_reg, 16'd0};
        kneg = 5'(-s1_tag_reg.k);
        if (s1_tag_reg.k[4]) begin
            mant = MANT_W'(m48 << kneg);
        end else begin
            mant = MANT_W'(m48 >> s1_tag_reg.k);
        end
        mneg     = mant < (34'd1 << 32);
        mag      = mneg ? MAG_W'((34'd1 << 32) - mant) : MAG_W'(mant - (34'd1 << 32));
        den_next = DEN_W'(mant) + (35'd1 << 32);
        num      = (63'(mag) << 30) + 63'(den_next >> 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_tag_reg.vld <= 1'b0;
        end else if (ce) begin
            s2_tag_reg.vld <= s1_tag_reg.vld;
        end
        if (ce) begin
            s2_tag_reg.err <= s1_tag_reg.err;
            s2_tag_reg.neg <= mneg;
            s2_tag_reg.k   <= s1_tag_reg.k;
            s2_hi_reg      <= num[62:30];
            s2_lo_reg      <= num[29:0];
            s2_den_reg     <= den_next;
        end
    end

    // Divider: |z| = round(|m-1| / (m+1)) in Q.30
    lnser_tag_t       dv_tag;
    logic [QUO_W-1:0] dv_quo;

    lnser_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .tag_in  (s2_tag_reg),
        .num_hi  (s2_hi_reg),
        .num_lo  (s2_lo_reg),
        .den     (s2_den_reg),
        .tag_out (dv_tag),
        .quo     (dv_quo)
    );

    // z squared, rounded to Q.30
    logic [2*QUO_W-1:0] zz;
    lnser_tag_t         sq_tag_reg;
    logic [QUO_W-1:0]   sq_a_reg;
    logic [QUO_W-1:0]   sq_aa_reg;

    assign zz = dv_quo * dv_quo + (60'd1 << 29);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_tag_reg.vld <= 1'b0;
        end else if (ce) begin
            sq_tag_reg.vld <= dv_tag.vld;
        end
        if (ce) begin
            sq_tag_reg.err <= dv_tag.err;
            sq_tag_reg.neg <= dv_tag.neg;
            sq_tag_reg.k   <= dv_tag.k;
            sq_a_reg       <= dv_quo;
            sq_aa_reg      <= QUO_W'(zz >> 30);
        end
    end

    // Series: two stages per odd term
    wire lnser_tag_t     tm_tag_w [0:SERIES_TERMS];
    wire [SUM_W-1:0]     tm_sum_w [0:SERIES_TERMS];
    wire [QUO_W-1:0]     tm_p_w   [0:SERIES_TERMS-1];
    wire [QUO_W-1:0]     tm_aa_w  [0:SERIES_TERMS-1];

    assign tm_tag_w[0] = sq_tag_reg;
    assign tm_sum_w[0] = '0;
    assign tm_p_w[0]   = sq_a_reg;
    assign tm_aa_w[0]  = sq_aa_reg;

    for (genvar i = 0; i < SERIES_TERMS; i++) begin : g_term
        localparam int          N_DIV = 2 * i + 1;
        localparam int          SHIFT = 30 + $clog2(N_DIV);
        localparam longint      RECIP = ((64'sd1 <<< SHIFT) + N_DIV - 1) / N_DIV;

        lnser_tag_t       ta_tag_reg;
        logic [SUM_W-1:0] ta_sum_reg;
        logic [63:0]      ta_div_reg;
        lnser_tag_t       tb_tag_reg;
        logic [SUM_W-1:0] tb_sum_reg;
        logic [QUO_W-1:0] rnd_in;

        // term / n by reciprocal multiply, rounded half up
        assign rnd_in = tm_p_w[i] + QUO_W'(N_DIV / 2);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ta_tag_reg.vld <= 1'b0;
                tb_tag_reg.vld <= 1'b0;
            end else if (ce) begin
                ta_tag_reg.vld <= tm_tag_w[i].vld;
                tb_tag_reg.vld <= ta_tag_reg.vld;
            end
            if (ce) begin
                ta_tag_reg.err <= tm_tag_w[i].err;
                ta_tag_reg.neg <= tm_tag_w[i].neg;
                ta_tag_reg.k   <= tm_tag_w[i].k;
                ta_sum_reg     <= tm_sum_w[i];
                ta_div_reg     <= 64'(rnd_in) * 64'(RECIP);
                tb_tag_reg.err <= ta_tag_reg.err;
                tb_tag_reg.neg <= ta_tag_reg.neg;
                tb_tag_reg.k   <= ta_tag_reg.k;
                tb_sum_reg     <= ta_sum_reg + SUM_W'(ta_div_reg >> SHIFT);
            end
        end

        assign tm_tag_w[i+1] = tb_tag_reg;
        assign tm_sum_w[i+1] = tb_sum_reg;

        // next odd power of |z|
        if (i < SERIES_TERMS - 1) begin : g_pow
            logic [2*QUO_W-1:0] pa_prod_reg;
            logic [QUO_W-1:0]   pa_aa_reg;
            logic [QUO_W-1:0]   pb_p_reg;
            logic [QUO_W-1:0]   pb_aa_reg;

            always_ff @(posedge aclk) begin
                if (ce) begin
                    pa_prod_reg <= tm_p_w[i] * tm_aa_w[i];
                    pa_aa_reg   <= tm_aa_w[i];
                    pb_p_reg    <= QUO_W'((pa_prod_reg + (60'd1 << 29)) >> 30);
                    pb_aa_reg   <= pa_aa_reg;
                end
            end

            assign tm_p_w[i+1]  = pb_p_reg;
            assign tm_aa_w[i+1] = pb_aa_reg;
        end
    end

    // Final 1: signed doubled sum plus k*ln2 in Q.30
    lnser_tag_t               sr_tag;
    logic signed [TOT_W-1:0]  sum2;
    logic signed [TOT_W-1:0]  f1_tot_reg;
    lnser_tag_t               f1_tag_reg;

    assign sr_tag = tm_tag_w[SERIES_TERMS];
    assign sum2   = TOT_W'(tm_sum_w[SERIES_TERMS]) <<< 1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_tag_reg.vld <= 1'b0;
        end else if (ce) begin
            f1_tag_reg.vld <= sr_tag.vld;
        end
        if (ce) begin
            f1_tag_reg.err <= sr_tag.err;
            f1_tag_reg.neg <= sr_tag.neg;
            f1_tag_reg.k   <= sr_tag.k;
            f1_tot_reg     <= (sr_tag.neg ? -sum2 : sum2) + TOT_W'(sr_tag.k) * LN2_Q30;
        end
    end

    // Final 2: round Q.30 to Q.26, ties away from zero; output register
    logic [TOT_W-1:0] tot_abs;
    logic [TOT_W-1:0] rnd_abs;
    logic [LOG_W-1:0] log_next;
    logic             out_vld_reg;
    logic [LOG_W-1:0] out_log_reg;
    logic             out_err_reg;

    always_comb begin
        tot_abs = f1_tot_reg[TOT_W-1] ? TOT_W'(-f1_tot_reg) : TOT_W'(f1_tot_reg);
        rnd_abs = (tot_abs + 40'd8) >> 4;
        if (f1_tag_reg.err) begin
            log_next = LOG_MIN;
        end else if (f1_tot_reg[TOT_W-1]) begin
            log_next = LOG_W'(-rnd_abs);
        end else begin
            log_next = LOG_W'(rnd_abs);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (ce) begin
            out_vld_reg <= f1_tag_reg.vld;
        end
        if (ce) begin
            out_log_reg <= log_next;
            out_err_reg <= f1_tag_reg.err;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_log_reg;
    assign m_tuser  = out_err_reg;

endmodule

### rtl/lnser_checker.sv
// Port-level assertions for the natural log series unit, with bind.
module lnser_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // domain error always reports the most negative value
    a_err_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 32'h8000_0000)
        else $error("domain error without minimum value");

    // a valid operand never lands on the error code
    a_ok_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata != 32'h8000_0000)
        else $error("result out of range");

    // empty output register never blocks input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // output empty right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("valid result after reset");

endmodule

bind natural_log_series_unit lnser_checker u_lnser_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### bench/tb_top.sv
// Testbench for natural_log_series_unit: random and directed operands, predicted log checked.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SERIES_TERMS = 5;
    localparam int LATENCY      = 36 + 2 * SERIES_TERMS;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [31:0] log_value;
        logic        domain_error;
    } log_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    logic [31:0] operand_queue[$];
    log_result_t expected_logs[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          send_gap = 0;
    int          take_gap = 0;
    bit          hold_sender = 1'b0;

    natural_log_series_unit #(.SERIES_TERMS(SERIES_TERMS)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Fixed-point log: range reduce, atanh series, add k*ln2, round to Q5.26
    function automatic log_result_t predict_log(logic [31:0] x);
        log_result_t res;
        logic [63:0] m, mag, den, a, aa, term, sum, n;
        longint      k, total, r;
        bit          neg;
        m = {16'd0, x, 16'd0};
        k = 0;
        if (x == 0) begin
            res.log_value = 32'h8000_0000;
            res.domain_error = 1'b1;
            return res;
        end
        while (m > (64'd2 << 32)) begin m = m >> 1; k++; end
        while (m < (64'd1 << 31)) begin m = m << 1; k--; end
        neg = m < (64'd1 << 32);
        mag = neg ? ((64'd1 << 32) - m) : (m - (64'd1 << 32));
        den = m + (64'd1 << 32);
        a = ((mag << 30) + (den >> 1)) / den;
        aa = (a * a + (64'd1 << 29)) >> 30;
        sum = 0;
        term = a;
        n = 1;
        for (int i = 0; i < SERIES_TERMS; i++) begin
            sum += (term + (n >> 1)) / n;
            term = (term * aa + (64'd1 << 29)) >> 30;
            n += 2;
        end
        sum = sum << 1;
        total = neg ? -longint'(sum) : longint'(sum);
        total += k * 64'sd744261118;
        if (total < 0) r = -longint'((64'(-total) + 8) >> 4);
        else           r = longint'((64'(total) + 8) >> 4);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        res.log_value = r[31:0];
        res.domain_error = 1'b0;
        return res;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Stimulus: directed corners, then random operands of varied magnitude
    initial begin
        logic [31:0] v;
        operand_queue.push_back(32'h0000_0000);
        operand_queue.push_back(32'h0000_0001);
        operand_queue.push_back(32'hFFFF_FFFF);
        operand_queue.push_back(32'h0001_0000);  // one
        operand_queue.push_back(32'h0002_0000);  // two, k stays zero
        operand_queue.push_back(32'h0000_8000);  // half
        operand_queue.push_back(32'h0002_0001);
        operand_queue.push_back(32'h0000_7FFF);
        operand_queue.push_back(32'h0000_FFFF);
        operand_queue.push_back(32'h0001_0001);
        operand_queue.push_back(32'h8000_0000);
        operand_queue.push_back(32'h7FFF_FFFF);
        operand_queue.push_back(32'hAAAA_AAAA);
        operand_queue.push_back(32'h5555_5555);
        operand_queue.push_back(32'h0002_B7E1);  // near e
        for (int i = 0; i < 1900; i++) begin
            v = $urandom();
            case ($urandom_range(3))
                0: v = v >> $urandom_range(31);
                1: v = 32'h0001_0000 + ($urandom_range(255) - 128);
                2: v = (32'd1 << $urandom_range(31)) + ($urandom_range(2) - 1);
                default: ;
            endcase
            operand_queue.push_back(v);
        end
    end

    // Drive requests into the unit
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_logs.push_back(predict_log(s_tdata));
            end
            if (!s_tvalid || s_tready) begin
                if (operand_queue.size() == 1400 && !hold_sender) begin
                    hold_sender = 1'b1;
                end
                if (hold_sender && (expected_logs.size() != 0 || (s_tvalid && s_tready))) begin
                    s_tvalid <= 1'b0;
                end else if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (operand_queue.size() != 0) begin
                    if (hold_sender && operand_queue.size() == 1400) hold_sender = 1'b0;
                    s_tdata  <= operand_queue.pop_front();
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Take and check results
    always @(posedge aclk) begin
        log_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_logs.size() == 0) begin
                    $display("%0t: unexpected result log_value=%h domain_error=%b",
                             $time, m_tdata, m_tuser);
                    error_count++;
                end else begin
                    want = expected_logs.pop_front();
                    if (m_tdata !== want.log_value) begin
                        $display("%0t: log_value expected %h actual %h",
                                 $time, want.log_value, m_tdata);
                        error_count++;
                    end
                    if (m_tuser !== want.domain_error) begin
                        $display("%0t: domain_error expected %b actual %b",
                                 $time, want.domain_error, m_tuser);
                        error_count++;
                    end
                end
            end
            if (take_gap > 0) begin
                take_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                take_gap = pick_gap();
            end
        end
    end

    // Reset, end of run and timeout
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        while (operand_queue.size() != 0 || s_tvalid || expected_logs.size() != 0) begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("natural_log_series_unit verification failed");
                $finish;
            end
        end
        repeat (LATENCY + 20) @(posedge aclk);
        if (error_count == 0 && expected_logs.size() == 0) begin
            $display("natural_log_series_unit verification clean");
        end else begin
            $display("natural_log_series_unit verification failed");
        end
        $finish;
    end
endmodule

### natural_log_series_unit.f
rtl/lnser_pkg.sv
rtl/lnser_div.sv
rtl/natural_log_series_unit.sv
rtl/lnser_checker.sv
bench/tb_top.sv
